/* rtl/krsm_pkg.sv */
package krsm_pkg;

    localparam int INDEX_DEPTH = 256;
    localparam int HOLE_DEPTH  = 256;
    localparam int IDX_W       = $clog2(INDEX_DEPTH);
    localparam int HOLE_W      = $clog2(HOLE_DEPTH);
    localparam int ICNT_W      = $clog2(INDEX_DEPTH + 1);
    localparam int HCNT_W      = $clog2(HOLE_DEPTH + 1);
    localparam logic [10:0] REC_OVERHEAD = 11'd7;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_FIND   = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_INDEX_FULL = 3'd3,
        ST_HOLE_FULL = 3'd4,
        ST_STORE_FULL = 3'd5
    } status_t;

    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [31:0] key;
        logic [9:0]         rec_len;
    } cmd_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] offset;
        logic [10:0] size;
    } result_item_t;

    typedef struct packed {
        logic [31:0] key;
        logic [31:0] offset;
        logic [10:0] size;
    } entry_t;

    typedef struct packed {
        logic [31:0] offset;
        logic [10:0] size;
    } hole_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_DECIDE,
        S_HOLE_RD,
        S_HOLE_CMP,
        S_HSHIFT_RD,
        S_HSHIFT_WR,
        S_HAPPEND,
        S_ISHIFT_RD,
        S_ISHIFT_WR,
        S_IWRITE,
        S_DSHIFT_RD,
        S_DSHIFT_WR,
        S_DONE
    } state_t;

endpackage

/* rtl/keyed_record_store_manager.sv */
// Keyed record store manager: sorted key index plus first-fit hole list.
// Command channel: drive cmd_in with start high while busy is low; the
// item is taken at that edge and busy rises the next cycle.
// Result channel: done pulses for one cycle with result valid; the receiver
// cannot stall, so the result must be captured in that cycle.
// Steps per item, each through the single read port of each table memory:
//   binary search: a read and a compare state per probe, up to 9 probes,
//   then a decide state
//   add: a read and a compare state per hole inspected in first-fit order,
//        a read and a write state per hole moved to close the gap and per
//        index entry moved to open the slot
//   delete: a read and a write state per index entry moved down
// Longest: an add into a nearly full index that walks a full hole list.
// Reset clears counts and the store end; table contents need no clearing,
// since nothing past a count is read. The next start is taken the cycle
// done is shown.
module keyed_record_store_manager (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  krsm_pkg::cmd_item_t     cmd_in,
    output logic                    busy,
    output logic                    done,
    output krsm_pkg::result_item_t  result
);

    logic                        ent_we;
    logic [krsm_pkg::IDX_W-1:0]  ent_waddr, ent_raddr;
    krsm_pkg::entry_t            ent_wdata, ent_rdata;
    logic                        hole_we;
    logic [krsm_pkg::HOLE_W-1:0] hole_waddr, hole_raddr;
    krsm_pkg::hole_t             hole_wdata, hole_rdata;

    krsm_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .cmd_in     (cmd_in),
        .busy       (busy),
        .done       (done),
        .result     (result),
        .ent_we     (ent_we),
        .ent_waddr  (ent_waddr),
        .ent_wdata  (ent_wdata),
        .ent_raddr  (ent_raddr),
        .ent_rdata  (ent_rdata),
        .hole_we    (hole_we),
        .hole_waddr (hole_waddr),
        .hole_wdata (hole_wdata),
        .hole_raddr (hole_raddr),
        .hole_rdata (hole_rdata)
    );

    krsm_ram #(
        .DEPTH (krsm_pkg::INDEX_DEPTH),
        .WIDTH ($bits(krsm_pkg::entry_t))
    ) u_index (
        .clk   (clk),
        .we    (ent_we),
        .waddr (ent_waddr),
        .wdata (ent_wdata),
        .raddr (ent_raddr),
        .rdata (ent_rdata)
    );

    krsm_ram #(
        .DEPTH (krsm_pkg::HOLE_DEPTH),
        .WIDTH ($bits(krsm_pkg::hole_t))
    ) u_holes (
        .clk   (clk),
        .we    (hole_we),
        .waddr (hole_waddr),
        .wdata (hole_wdata),
        .raddr (hole_raddr),
        .rdata (hole_rdata)
    );

endmodule

/* rtl/krsm_ram.sv */
module krsm_ram #(
    parameter int DEPTH  = 256,
    parameter int WIDTH  = 8,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/krsm_seq.sv */
module krsm_seq (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  krsm_pkg::cmd_item_t           cmd_in,
    output logic                          busy,
    output logic                          done,
    output krsm_pkg::result_item_t        result,
    output logic                          ent_we,
    output logic [krsm_pkg::IDX_W-1:0]    ent_waddr,
    output krsm_pkg::entry_t              ent_wdata,
    output logic [krsm_pkg::IDX_W-1:0]    ent_raddr,
    input  krsm_pkg::entry_t              ent_rdata,
    output logic                          hole_we,
    output logic [krsm_pkg::HOLE_W-1:0]   hole_waddr,
    output krsm_pkg::hole_t               hole_wdata,
    output logic [krsm_pkg::HOLE_W-1:0]   hole_raddr,
    input  krsm_pkg::hole_t               hole_rdata
);

    localparam int IW = krsm_pkg::IDX_W;
    localparam int HW = krsm_pkg::HOLE_W;
    localparam int IC = krsm_pkg::ICNT_W;
    localparam int HC = krsm_pkg::HCNT_W;

    krsm_pkg::state_t state_reg, state_next;
    krsm_pkg::cmd_item_t item_reg, item_next;
    logic [IC-1:0] ecnt_reg, ecnt_next;
    logic [HC-1:0] hcnt_reg, hcnt_next;
    logic [31:0]   send_reg, send_next;
    logic [IC-1:0] lo_reg, lo_next, hi_reg, hi_next;
    logic          found_reg, found_next;
    logic [IC-1:0] pos_reg, pos_next;
    logic [IC-1:0] icur_reg, icur_next;
    logic [HC-1:0] hcur_reg, hcur_next;
    krsm_pkg::entry_t ent_reg, ent_next;
    logic [31:0]   place_reg, place_next;
    logic [10:0]   rest_reg, rest_next;
    krsm_pkg::result_item_t res_reg, res_next;
    logic          done_reg, done_next;

    logic [10:0] need;
    logic [IC-1:0] mid;
    logic [32:0] end_sum;
    logic signed [31:0] rkey;

    assign need    = {1'b0, item_reg.rec_len} + krsm_pkg::REC_OVERHEAD;
    assign mid     = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign end_sum = {1'b0, send_reg} + {22'd0, need};
    assign rkey    = ent_rdata.key;

    assign busy   = (state_reg != krsm_pkg::S_IDLE);
    assign done   = done_reg;
    assign result = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= krsm_pkg::S_IDLE;
            ecnt_reg  <= '0;
            hcnt_reg  <= '0;
            send_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ecnt_reg  <= ecnt_next;
            hcnt_reg  <= hcnt_next;
            send_reg  <= send_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg  <= item_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        found_reg <= found_next;
        pos_reg   <= pos_next;
        icur_reg  <= icur_next;
        hcur_reg  <= hcur_next;
        ent_reg   <= ent_next;
        place_reg <= place_next;
        rest_reg  <= rest_next;
        res_reg   <= res_next;
    end

    always_comb
    begin
        state_next = state_reg;
        item_next  = item_reg;
        ecnt_next  = ecnt_reg;
        hcnt_next  = hcnt_reg;
        send_next  = send_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        found_next = found_reg;
        pos_next   = pos_reg;
        icur_next  = icur_reg;
        hcur_next  = hcur_reg;
        ent_next   = ent_reg;
        place_next = place_reg;
        rest_next  = rest_reg;
        res_next   = res_reg;
        done_next  = 1'b0;
        ent_we     = 1'b0;
        ent_waddr  = icur_reg[IW-1:0];
        ent_wdata  = ent_rdata;
        ent_raddr  = mid[IW-1:0];
        hole_we    = 1'b0;
        hole_waddr = hcur_reg[HW-1:0];
        hole_wdata = hole_rdata;
        hole_raddr = hcur_reg[HW-1:0];

        unique case (state_reg)
            krsm_pkg::S_IDLE:
            begin
                if (start)
                begin
                    item_next  = cmd_in;
                    lo_next    = '0;
                    hi_next    = ecnt_reg;
                    found_next = 1'b0;
                    res_next   = '0;
                    state_next = krsm_pkg::S_SRCH_RD;
                end
            end
            krsm_pkg::S_SRCH_RD:
            begin
                // probe the middle of the window
                if (lo_reg < hi_reg)
                begin
                    state_next = krsm_pkg::S_SRCH_CMP;
                end
                else
                begin
                    pos_next   = lo_reg;
                    state_next = krsm_pkg::S_DECIDE;
                end
            end
            krsm_pkg::S_SRCH_CMP:
            begin
                ent_raddr = mid[IW-1:0];
                if (rkey == item_reg.key)
                begin
                    found_next = 1'b1;
                    pos_next   = mid;
                    ent_next   = ent_rdata;
                    state_next = krsm_pkg::S_DECIDE;
                end
                else
                begin
                    if (item_reg.key < rkey)
                    begin
                        hi_next = mid;
                    end
                    else
                    begin
                        lo_next = mid + 1'b1;
                    end
                    state_next = krsm_pkg::S_SRCH_RD;
                end
            end
            krsm_pkg::S_DECIDE:
            begin
                hcur_next  = '0;
                state_next = krsm_pkg::S_DONE;
                unique case (item_reg.cmd)
                    krsm_pkg::CMD_ADD:
                    begin
                        if (found_reg)
                        begin
                            res_next.status = krsm_pkg::ST_DUPLICATE;
                        end
                        else if (ecnt_reg >= IC'(krsm_pkg::INDEX_DEPTH))
                        begin
                            res_next.status = krsm_pkg::ST_INDEX_FULL;
                        end
                        else
                        begin
                            state_next = krsm_pkg::S_HOLE_RD;
                        end
                    end
                    krsm_pkg::CMD_FIND:
                    begin
                        if (found_reg)
                        begin
                            res_next.offset = ent_reg.offset;
                            res_next.size   = ent_reg.size;
                        end
                        else
                        begin
                            res_next.status = krsm_pkg::ST_NOT_FOUND;
                        end
                    end
                    krsm_pkg::CMD_DELETE:
                    begin
                        if (!found_reg)
                        begin
                            res_next.status = krsm_pkg::ST_NOT_FOUND;
                        end
                        else if (hcnt_reg >= HC'(krsm_pkg::HOLE_DEPTH))
                        begin
                            res_next.status = krsm_pkg::ST_HOLE_FULL;
                        end
                        else
                        begin
                            res_next.offset = ent_reg.offset;
                            res_next.size   = ent_reg.size;
                            hole_we          = 1'b1;
                            hole_waddr       = hcnt_reg[HW-1:0];
                            hole_wdata.offset = ent_reg.offset;
                            hole_wdata.size  = ent_reg.size;
                            hcnt_next        = hcnt_reg + 1'b1;
                            icur_next        = pos_reg;
                            state_next       = krsm_pkg::S_DSHIFT_RD;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            krsm_pkg::S_HOLE_RD:
            begin
                // first-fit walk, one hole per pass through the read and compare states
                if (hcur_reg < hcnt_reg)
                begin
                    state_next = krsm_pkg::S_HOLE_CMP;
                end
                else if (!end_sum[32])
                begin
                    place_next = send_reg;
                    send_next  = end_sum[31:0];
                    icur_next  = ecnt_reg;
                    state_next = krsm_pkg::S_ISHIFT_RD;
                end
                else
                begin
                    res_next.status = krsm_pkg::ST_STORE_FULL;
                    state_next      = krsm_pkg::S_DONE;
                end
            end
            krsm_pkg::S_HOLE_CMP:
            begin
                if (hole_rdata.size >= need)
                begin
                    place_next = hole_rdata.offset;
                    rest_next  = hole_rdata.size - need;
                    state_next = krsm_pkg::S_HSHIFT_RD;
                end
                else
                begin
                    hcur_next  = hcur_reg + 1'b1;
                    state_next = krsm_pkg::S_HOLE_RD;
                end
            end
            krsm_pkg::S_HSHIFT_RD:
            begin
                // close the gap left by the chosen hole
                if (hcur_reg + 1'b1 < hcnt_reg)
                begin
                    hole_raddr = HW'(hcur_reg + 1'b1);
                    state_next = krsm_pkg::S_HSHIFT_WR;
                end
                else
                begin
                    hcnt_next  = hcnt_reg - 1'b1;
                    state_next = krsm_pkg::S_HAPPEND;
                end
            end
            krsm_pkg::S_HSHIFT_WR:
            begin
                hole_we    = 1'b1;
                hole_wdata = hole_rdata;
                hcur_next  = hcur_reg + 1'b1;
                state_next = krsm_pkg::S_HSHIFT_RD;
            end
            krsm_pkg::S_HAPPEND:
            begin
                if (rest_reg != 11'd0)
                begin
                    hole_we           = 1'b1;
                    hole_waddr        = hcnt_reg[HW-1:0];
                    hole_wdata.offset = place_reg + {21'd0, need};
                    hole_wdata.size   = rest_reg;
                    hcnt_next         = hcnt_reg + 1'b1;
                end
                icur_next  = ecnt_reg;
                state_next = krsm_pkg::S_ISHIFT_RD;
            end
            krsm_pkg::S_ISHIFT_RD:
            begin
                // open a slot at the insert position, walking down from the top
                if (icur_reg > pos_reg)
                begin
                    ent_raddr  = IW'(icur_reg - 1'b1);
                    state_next = krsm_pkg::S_ISHIFT_WR;
                end
                else
                begin
                    state_next = krsm_pkg::S_IWRITE;
                end
            end
            krsm_pkg::S_ISHIFT_WR:
            begin
                ent_we     = 1'b1;
                ent_wdata  = ent_rdata;
                icur_next  = icur_reg - 1'b1;
                state_next = krsm_pkg::S_ISHIFT_RD;
            end
            krsm_pkg::S_IWRITE:
            begin
                ent_we           = 1'b1;
                ent_waddr        = pos_reg[IW-1:0];
                ent_wdata.key    = item_reg.key;
                ent_wdata.offset = place_reg;
                ent_wdata.size   = need;
                ecnt_next        = ecnt_reg + 1'b1;
                res_next.offset  = place_reg;
                res_next.size    = need;
                state_next       = krsm_pkg::S_DONE;
            end
            krsm_pkg::S_DSHIFT_RD:
            begin
                if (icur_reg + 1'b1 < ecnt_reg)
                begin
                    ent_raddr  = IW'(icur_reg + 1'b1);
                    state_next = krsm_pkg::S_DSHIFT_WR;
                end
                else
                begin
                    ecnt_next  = ecnt_reg - 1'b1;
                    state_next = krsm_pkg::S_DONE;
                end
            end
            krsm_pkg::S_DSHIFT_WR:
            begin
                ent_we     = 1'b1;
                ent_wdata  = ent_rdata;
                icur_next  = icur_reg + 1'b1;
                state_next = krsm_pkg::S_DSHIFT_RD;
            end
            krsm_pkg::S_DONE:
            begin
                done_next  = 1'b1;
                state_next = krsm_pkg::S_IDLE;
            end
            default:
            begin
                state_next = krsm_pkg::S_IDLE;
            end
        endcase
    end

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        ecnt_reg <= IC'(krsm_pkg::INDEX_DEPTH) && hcnt_reg <= HC'(krsm_pkg::HOLE_DEPTH))
        else $error("count out of range");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("done longer than one cycle");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> state_reg == krsm_pkg::S_IDLE)
        else $error("done while busy");
    a_store_grow: assert property (@(posedge clk) disable iff (!rst_n)
        send_reg >= $past(send_reg) || $past(!rst_n))
        else $error("store end shrank");
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && res_reg.status != krsm_pkg::ST_OK |-> res_reg.size == 11'd0)
        else $error("size on error result");

endmodule
